[rtl/core/mdm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mdm_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Fixed register and arithmetic widths.
    localparam int DELAY_W = 13;
    localparam int COUNT_W = 3;
    localparam int Q16_W   = 17;
    localparam int MIX_W   = 25;

    localparam logic [Q16_W-1:0] ONE_Q16  = 17'h10000;
    localparam logic [MIX_W-1:0] HALF_Q24 = 25'h0800000;

    // Register reset values.
    localparam logic [DELAY_W-1:0] DELAY_RST  = 13'd4800;
    localparam logic [COUNT_W-1:0] COUNT_RST  = 3'd2;
    localparam logic [Q16_W-1:0]   TARGET_RST = 17'd32768;
    localparam logic [Q16_W-1:0]   COEFF_RST  = 17'd273;

    // Queue depths between the parts of the block.
    localparam int Q_FIFO_DEPTH   = 2;
    localparam int OUT_FIFO_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY_FRAMES    = 2'd0,
        CFG_CHANNEL_COUNT   = 2'd1,
        CFG_MIX_TARGET      = 2'd2,
        CFG_SMOOTHING_COEFF = 2'd3
    } cfg_index_t;

    // Effective configuration, already clamped to its legal ranges.
    typedef struct packed {
        logic [DELAY_W-1:0] delay;
        logic [COUNT_W-1:0] count;
        logic [Q16_W-1:0]   mix_target;
        logic [Q16_W-1:0]   coeff;
    } cfg_t;

endpackage

`default_nettype wire

[rtl/core/multichannel_delay_mix_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Multichannel delay line with a smoothed dry/wet mix. Interleaved audio
// samples in signed Q1.23 (channel 0 first) arrive as beats on the s_ side,
// and each beat leaves one mixed beat on the m_ side, carrying the channel in
// m_tuser and an end-of-frame flag in m_tlast. Every sample is written into a
// store of FRAME_DEPTH frames and the same channel's sample from delay_frames
// frames earlier is read back; a delay of zero passes the input through. The
// wet share glides toward mix_target by one one-pole step per sample, and the
// output is x + m*(delayed - x), rounded to nearest with ties away from zero.
// The block takes no new beat while the last one is in stage one, as the mix
// recurrence registers its product there and must accumulate into the mix
// value before the next sample uses it. A beat passes the stage one, two and
// three registers from the item queue to the output queue. After reset the
// delay store is cleared one entry per cycle, FRAME_DEPTH times MAX_CHANNELS
// rounded up to a power of two, at least two (32768 entries by default), and
// s_tready stays low until that pass is done. Configuration writes take
// effect at once and should only be issued while no beat is in flight; values
// are clamped when written, delay and count after truncating to field width.

module multichannel_delay_mix_unit
    import mdm_pkg::*;
#(
    parameter int FRAME_DEPTH  = 8192,
    parameter int MAX_CHANNELS = 4,
    parameter int SAMPLE_BITS  = 24,
    localparam int DATA_BYTES  = (SAMPLE_BITS + 7) / 8
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // Configuration write port.
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_wdata,
    // Input stream.
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [DATA_BYTES*8-1:0] s_tdata,   // sample_in
    // Output stream.
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic      [DATA_BYTES*8-1:0] m_tdata,   // sample_out
    output logic      [1:0]              m_tuser,   // channel_index
    output logic                         m_tlast    // frame_end
);

    localparam int FW   = $clog2(FRAME_DEPTH);
    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int AW   = FW + CH_W;
    // Width of the work item between front and back (see mdm_front).
    localparam int QW   = SAMPLE_BITS + 2 * AW + CH_W + 3;
    localparam int OW   = SAMPLE_BITS + 3;

    // Register value limits that follow from the parameters.
    localparam int DMAX = (FRAME_DEPTH - 1 < 8191) ? FRAME_DEPTH - 1 : 8191;
    localparam int CMAX = (MAX_CHANNELS < 7) ? MAX_CHANNELS : 7;
    localparam logic [DELAY_W-1:0] DELAY_MAX = DELAY_W'(DMAX);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(CMAX);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [1:0]             chan;
        logic                   last;
    } out_t;

    cfg_t cfg_reg, cfg_next;

    logic [DELAY_W-1:0] wr_delay;
    logic [COUNT_W-1:0] wr_count;
    logic [Q16_W-1:0]   wr_q16;

    logic          clear_done;
    logic          q_in_valid, q_in_ready;
    logic [QW-1:0] q_in_data;
    logic          q_out_valid, q_out_ready;
    logic [QW-1:0] q_out_data;
    logic          push_valid;
    logic [OW-1:0] push_data;
    logic          out_pop;
    out_t          out_head;

    // Write-side clamping: the stored value is what the datapath uses.
    assign wr_delay = (cfg_wdata[DELAY_W-1:0] > DELAY_MAX) ? DELAY_MAX
                                                           : cfg_wdata[DELAY_W-1:0];
    assign wr_q16   = (cfg_wdata > ONE_Q16) ? ONE_Q16 : cfg_wdata;

    always_comb
    begin
        if (cfg_wdata[COUNT_W-1:0] == '0)
        begin
            wr_count = COUNT_W'(1);
        end
        else if (cfg_wdata[COUNT_W-1:0] > COUNT_MAX)
        begin
            wr_count = COUNT_MAX;
        end
        else
        begin
            wr_count = cfg_wdata[COUNT_W-1:0];
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_DELAY_FRAMES:    cfg_next.delay      = wr_delay;
                CFG_CHANNEL_COUNT:   cfg_next.count      = wr_count;
                CFG_MIX_TARGET:      cfg_next.mix_target = wr_q16;
                CFG_SMOOTHING_COEFF: cfg_next.coeff      = wr_q16;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delay      <= (DELAY_RST > DELAY_MAX) ? DELAY_MAX : DELAY_RST;
            cfg_reg.count      <= (COUNT_RST > COUNT_MAX) ? COUNT_MAX : COUNT_RST;
            cfg_reg.mix_target <= TARGET_RST;
            cfg_reg.coeff      <= COEFF_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: channel and frame bookkeeping, store addresses.
    mdm_front #(
        .FRAME_DEPTH  (FRAME_DEPTH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .enable    (clear_done),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sample (s_tdata[SAMPLE_BITS-1:0]),
        .q_valid   (q_in_valid),
        .q_ready   (q_in_ready),
        .q_item    (q_in_data)
    );

    // Short queue that decouples the front from the back.
    mdm_fifo #(
        .WIDTH (QW),
        .DEPTH (Q_FIFO_DEPTH)
    ) u_item_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_data   (q_in_data),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_word  (q_out_data)
    );

    // Back: delay store, mix recurrence and output arithmetic.
    mdm_back #(
        .FRAME_DEPTH  (FRAME_DEPTH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .clear_done (clear_done),
        .q_valid    (q_out_valid),
        .q_ready    (q_out_ready),
        .q_item     (q_out_data),
        .push_valid (push_valid),
        .push_data  (push_data),
        .out_pop    (out_pop)
    );

    // Output queue; the back never issues more beats than it can hold.
    mdm_fifo #(
        .WIDTH (OW),
        .DEPTH (OUT_FIFO_DEPTH)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (),
        .in_data   (push_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_head)
    );

    assign out_pop = m_tvalid & m_tready;
    assign m_tdata = (DATA_BYTES * 8)'(out_head.sample);
    assign m_tuser = out_head.chan;
    assign m_tlast = out_head.last;

endmodule

`default_nettype wire

[rtl/core/mdm_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module mdm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [WIDTH-1:0] out_word
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_word  = store_reg[rd_ptr_reg];
    assign push      = in_valid & in_ready;
    assign pop       = out_valid & out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

[rtl/core/mdm_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module mdm_front
    import mdm_pkg::*;
#(
    parameter int FRAME_DEPTH  = 8192,
    parameter int MAX_CHANNELS = 4,
    parameter int SAMPLE_BITS  = 24,
    localparam int FW   = $clog2(FRAME_DEPTH),
    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
    localparam int AW   = FW + CH_W,
    localparam int QW   = SAMPLE_BITS + 2 * AW + CH_W + 3
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cfg_t                   cfg,
    input  wire logic                   enable,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [SAMPLE_BITS-1:0] in_sample,
    output logic                        q_valid,
    input  wire logic                   q_ready,
    output logic      [QW-1:0]          q_item
);

    // Work item handed to the back part; the layout is shared with mdm_back.
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] x;
        logic [AW-1:0]          wr_addr;
        logic [AW-1:0]          rd_addr;
        logic                   pass;
        logic [CH_W-1:0]        ch;
        logic                   last;
        logic                   spare;
    } item_t;

    localparam int RW = ((FW > DELAY_W) ? FW : DELAY_W) + 1;

    logic [FW-1:0]   frame_reg, frame_next;
    logic [CH_W-1:0] pos_reg, pos_next;
    logic [5:0]      pos_ext, cnt_m1;
    logic            last;
    logic [RW-1:0]   wf_ext, d_ext, rd_wide;
    logic [FW-1:0]   rd_frame;
    logic            accept;
    item_t           item;

    assign in_ready = enable & q_ready;
    assign q_valid  = enable & in_valid;
    assign accept   = in_valid & in_ready;

    // A position at or past the last channel closes the frame.
    assign pos_ext = 6'(pos_reg);
    assign cnt_m1  = 6'(cfg.count) - 6'd1;
    assign last    = (pos_ext >= cnt_m1);

    assign wf_ext = RW'(frame_reg);
    assign d_ext  = RW'(cfg.delay);

    always_comb
    begin
        if (wf_ext >= d_ext)
        begin
            rd_wide = wf_ext - d_ext;
        end
        else
        begin
            rd_wide = wf_ext + RW'(FRAME_DEPTH) - d_ext;
        end
        rd_frame = rd_wide[FW-1:0];
    end

    always_comb
    begin
        item.x       = in_sample;
        item.wr_addr = {frame_reg, pos_reg};
        item.rd_addr = {rd_frame, pos_reg};
        item.pass    = (cfg.delay == '0);
        item.ch      = pos_reg;
        item.last    = last;
        item.spare   = 1'b0;
    end

    assign q_item = item;

    always_comb
    begin
        frame_next = frame_reg;
        pos_next   = pos_reg;
        if (accept)
        begin
            if (last)
            begin
                pos_next   = '0;
                frame_next = (frame_reg == FW'(FRAME_DEPTH - 1)) ? '0 : frame_reg + 1'b1;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            frame_reg <= frame_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/mdm_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module mdm_back
    import mdm_pkg::*;
#(
    parameter int FRAME_DEPTH  = 8192,
    parameter int MAX_CHANNELS = 4,
    parameter int SAMPLE_BITS  = 24,
    localparam int FW   = $clog2(FRAME_DEPTH),
    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
    localparam int AW   = FW + CH_W,
    localparam int QW   = SAMPLE_BITS + 2 * AW + CH_W + 3,
    localparam int OW   = SAMPLE_BITS + 3
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cfg_t          cfg,
    output logic               clear_done,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire logic [QW-1:0] q_item,
    output logic               push_valid,
    output logic      [OW-1:0] push_data,
    input  wire logic          out_pop
);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] x;
        logic [AW-1:0]          wr_addr;
        logic [AW-1:0]          rd_addr;
        logic                   pass;
        logic [CH_W-1:0]        ch;
        logic                   last;
        logic                   spare;
    } item_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [1:0]             chan;
        logic                   last;
    } out_t;

    localparam int SB        = SAMPLE_BITS;
    localparam int MEM_DEPTH = FRAME_DEPTH * (2 ** CH_W);
    localparam int CRED_W    = $clog2(OUT_FIFO_DEPTH + 1);
    localparam int MP_W      = Q16_W + MIX_W;
    localparam int OP_W      = MIX_W + SB + 1;

    item_t item;
    out_t  result;
    logic  issue;

    // Delay store and its clearing pass.
    logic [SB-1:0] mem [MEM_DEPTH];
    logic [AW-1:0] clr_addr_reg;
    logic          clearing_reg;
    logic [SB-1:0] rd_data_reg;

    // Item accounting against the output queue.
    logic [CRED_W-1:0] credit_reg, credit_next;

    // Mix recurrence.
    logic [MIX_W-1:0] mix_reg, mix_next;
    logic [MIX_W-1:0] tgt_q24;
    logic [MIX_W:0]   mix_diff;
    logic [MIX_W-1:0] mix_mag;
    logic [MP_W-1:0]  mix_prod_reg;
    logic             mix_neg_reg;
    logic [MP_W-1:0]  mix_rnd_wide;
    logic [MIX_W-1:0] mix_rnd;

    // Stage one: store access and mix product.
    logic            s1_valid_reg;
    logic [SB-1:0]   s1_x_reg;
    logic            s1_pass_reg;
    logic [CH_W-1:0] s1_ch_reg;
    logic            s1_last_reg;
    logic [SB-1:0]   delayed;

    // Stage two: wet minus dry.
    logic            s2_valid_reg;
    logic [SB:0]     s2_diff_reg;
    logic [SB-1:0]   s2_x_reg;
    logic [CH_W-1:0] s2_ch_reg;
    logic            s2_last_reg;
    logic            s2_neg;
    logic [SB:0]     s2_mag;

    // Stage three: scaled difference, rounding and saturation.
    logic            s3_valid_reg;
    logic [OP_W-1:0] s3_prod_reg;
    logic            s3_neg_reg;
    logic [SB-1:0]   s3_x_reg;
    logic [CH_W-1:0] s3_ch_reg;
    logic            s3_last_reg;
    logic [OP_W-1:0] out_rnd_wide;
    logic [SB+1:0]   out_rnd;
    logic [SB+1:0]   y_wide;
    logic [SB+1:0]   y_hi, y_lo;
    logic [SB-1:0]   y_sat;

    assign item       = q_item;
    assign clear_done = ~clearing_reg;

    // No item enters while one is in stage one: the mix value is settled.
    assign q_ready = ~clearing_reg & ~s1_valid_reg & (credit_reg < CRED_W'(OUT_FIFO_DEPTH));
    assign issue   = q_valid & q_ready;

    always_comb
    begin
        credit_next = credit_reg;
        if (issue && !out_pop)
        begin
            credit_next = credit_reg + 1'b1;
        end
        else if (out_pop && !issue)
        begin
            credit_next = credit_reg - 1'b1;
        end
    end

    // Mix step operands.
    assign tgt_q24  = {cfg.mix_target, 8'b0};
    assign mix_diff = {1'b0, tgt_q24} - {1'b0, mix_reg};
    assign mix_mag  = mix_diff[MIX_W] ? MIX_W'(-mix_diff) : mix_diff[MIX_W-1:0];

    assign mix_rnd_wide = (mix_prod_reg + MP_W'(32768)) >> 16;
    assign mix_rnd      = mix_rnd_wide[MIX_W-1:0];

    always_comb
    begin
        mix_next = mix_reg;
        if (s1_valid_reg)
        begin
            mix_next = mix_neg_reg ? (mix_reg - mix_rnd) : (mix_reg + mix_rnd);
        end
    end

    assign delayed = s1_pass_reg ? s1_x_reg : rd_data_reg;

    assign s2_neg = s2_diff_reg[SB];
    assign s2_mag = s2_neg ? (SB + 1)'(-s2_diff_reg) : s2_diff_reg;

    assign out_rnd_wide = (s3_prod_reg + OP_W'(24'h800000)) >> 24;
    assign out_rnd      = out_rnd_wide[SB+1:0];

    assign y_hi   = {3'b000, {(SB - 1){1'b1}}};
    assign y_lo   = {3'b111, {(SB - 1){1'b0}}};
    assign y_wide = s3_neg_reg ? ((SB + 2)'($signed(s3_x_reg)) - out_rnd)
                               : ((SB + 2)'($signed(s3_x_reg)) + out_rnd);

    always_comb
    begin
        if ($signed(y_wide) > $signed(y_hi))
        begin
            y_sat = y_hi[SB-1:0];
        end
        else if ($signed(y_wide) < $signed(y_lo))
        begin
            y_sat = y_lo[SB-1:0];
        end
        else
        begin
            y_sat = y_wide[SB-1:0];
        end
    end

    always_comb
    begin
        result.sample = y_sat;
        result.chan   = 2'(s3_ch_reg);
        result.last   = s3_last_reg;
    end

    assign push_valid = s3_valid_reg;
    assign push_data  = result;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            credit_reg   <= '0;
            mix_reg      <= HALF_Q24;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                if (clr_addr_reg == AW'(MEM_DEPTH - 1))
                begin
                    clearing_reg <= 1'b0;
                end
                else
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                end
            end
            credit_reg   <= credit_next;
            mix_reg      <= mix_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Delay store: one write and one registered read per issued item.
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (issue)
        begin
            mem[item.wr_addr] <= item.x;
        end
        if (issue)
        begin
            rd_data_reg <= mem[item.rd_addr];
        end
    end

    // Payload pipeline.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_x_reg     <= item.x;
            s1_pass_reg  <= item.pass;
            s1_ch_reg    <= item.ch;
            s1_last_reg  <= item.last;
            mix_prod_reg <= MP_W'(cfg.coeff) * MP_W'(mix_mag);
            mix_neg_reg  <= mix_diff[MIX_W];
        end
        s2_diff_reg <= (SB + 1)'($signed(delayed)) - (SB + 1)'($signed(s1_x_reg));
        s2_x_reg    <= s1_x_reg;
        s2_ch_reg   <= s1_ch_reg;
        s2_last_reg <= s1_last_reg;
        s3_prod_reg <= OP_W'(mix_reg) * OP_W'(s2_mag);
        s3_neg_reg  <= s2_neg;
        s3_x_reg    <= s2_x_reg;
        s3_ch_reg   <= s2_ch_reg;
        s3_last_reg <= s2_last_reg;
    end

endmodule

`default_nettype wire
